// ===== sv/kpp_pkg.sv =====
// ----------------------------------------------------------------------------
// kpp_pkg
// Shared types and constants for the key press / page / screen controller.
// ----------------------------------------------------------------------------
package kpp_pkg;

    // Field widths
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned CLICK_W = 10;
    localparam int unsigned EV_W    = 2;
    localparam int unsigned PAGE_W  = 2;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CFG_W   = 16;

    // Key event codes
    localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_W-1:0] EV_CLICK = 2'd1;
    localparam logic [EV_W-1:0] EV_LONG  = 2'd2;

    // Page codes
    localparam logic [PAGE_W-1:0] PAGE_HOME  = 2'd0;
    localparam logic [PAGE_W-1:0] PAGE_TEMP  = 2'd1;
    localparam logic [PAGE_W-1:0] PAGE_LIGHT = 2'd2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [IDX_W-1:0] REG_CLICK_MIN  = 2'd1;
    localparam logic [IDX_W-1:0] REG_IDLE_TMO   = 2'd2;

    // Configuration reset values
    localparam logic [CNT_W-1:0]   LONG_PRESS_RST = 16'd1500;
    localparam logic [CLICK_W-1:0] CLICK_MIN_RST  = 10'd20;
    localparam logic [CNT_W-1:0]   IDLE_TMO_RST   = 16'd30000;

    // Key scanner to screen control
    typedef struct packed {
        logic            down;
        logic [EV_W-1:0] event_code;
    } key_status_t;

    // Screen control to output stage
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              lit;
        logic              redraw;
        logic              clear;
    } screen_status_t;

    // Saturating increment of an elapsed counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// ===== sv/kpp_key_scan.sv =====
// ----------------------------------------------------------------------------
// kpp_key_scan
// Press tracking: detects a long press while held and a click on release.
// ----------------------------------------------------------------------------
module kpp_key_scan import kpp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,      // one tick item taken
    input  logic               btn_pressed,
    input  logic [CNT_W-1:0]   long_ticks,
    input  logic [CLICK_W-1:0] click_ticks,
    output key_status_t        status
);

    logic             pressed_reg, pressed_next;
    logic             long_sent_reg, long_sent_next;
    logic [CNT_W-1:0] elapsed_reg, elapsed_next;
    logic [CNT_W-1:0] elapsed_inc;
    logic [EV_W-1:0]  ev;

    assign elapsed_inc = sat_inc(elapsed_reg);

    // Press / release decode for this tick
    always_comb begin
        pressed_next   = pressed_reg;
        long_sent_next = long_sent_reg;
        elapsed_next   = elapsed_reg;
        ev             = EV_NONE;
        if (!pressed_reg) begin
            if (btn_pressed) begin
                pressed_next   = 1'b1;
                elapsed_next   = '0;
                long_sent_next = 1'b0;
            end
        end else begin
            elapsed_next = elapsed_inc;
            if (btn_pressed) begin
                if (!long_sent_reg && (elapsed_inc >= long_ticks)) begin
                    long_sent_next = 1'b1;
                    ev             = EV_LONG;
                end
            end else begin
                pressed_next = 1'b0;
                if (!long_sent_reg && (elapsed_inc >= {{(CNT_W-CLICK_W){1'b0}}, click_ticks}))
                    ev = EV_CLICK;
            end
        end
    end

    assign status.down       = btn_pressed;
    assign status.event_code = ev;

    // Press state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg   <= 1'b0;
            long_sent_reg <= 1'b0;
            elapsed_reg   <= '0;
        end else if (advance) begin
            pressed_reg   <= pressed_next;
            long_sent_reg <= long_sent_next;
            elapsed_reg   <= elapsed_next;
        end
    end

endmodule

// ===== sv/kpp_screen_ctrl.sv =====
// ----------------------------------------------------------------------------
// kpp_screen_ctrl
// Page selection, screen wake / idle blanking and redraw request tracking.
// ----------------------------------------------------------------------------
module kpp_screen_ctrl import kpp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  key_status_t      key,
    input  logic [CNT_W-1:0] idle_ticks,
    output screen_status_t   status
);

    logic [CNT_W-1:0]  idle_reg, idle_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic              lit_reg, lit_next;
    logic              pend_reg, pend_next;
    logic              clr, draw;

    always_comb begin
        idle_next = sat_inc(idle_reg);
        page_next = page_reg;
        lit_next  = lit_reg;
        pend_next = pend_reg;
        clr       = 1'b0;
        draw      = 1'b0;

        // Key event: wake or change page
        if (key.event_code != EV_NONE) begin
            idle_next = '0;
            pend_next = 1'b1;
            if (key.event_code == EV_LONG) begin
                page_next = PAGE_HOME;
            end else if (lit_reg) begin
                case (page_reg)
                    PAGE_HOME: page_next = PAGE_TEMP;
                    PAGE_TEMP: page_next = PAGE_LIGHT;
                    default:   page_next = PAGE_TEMP;
                endcase
            end
            lit_next = 1'b1;
        end

        // Idle blanking, held off while the key is down
        if (!key.down && lit_next && (idle_next >= idle_ticks)) begin
            clr       = 1'b1;
            lit_next  = 1'b0;
            pend_next = 1'b0;
        end

        // One-tick redraw while lit
        if (lit_next && pend_next) begin
            pend_next = 1'b0;
            draw      = 1'b1;
        end
    end

    assign status.page   = page_next;
    assign status.lit    = lit_next;
    assign status.redraw = draw;
    assign status.clear  = clr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_reg <= '0;
            page_reg <= PAGE_HOME;
            lit_reg  <= 1'b1;
            pend_reg <= 1'b1;
        end else if (advance) begin
            idle_reg <= idle_next;
            page_reg <= page_next;
            lit_reg  <= lit_next;
            pend_reg <= pend_next;
        end
    end

endmodule

// ===== sv/key_press_page_screen_controller.sv =====
// ----------------------------------------------------------------------------
// key_press_page_screen_controller
// Button click / long-press detector driving page selection and screen power.
// ----------------------------------------------------------------------------
// Each input item is one tick carrying the sampled button level; each item
// gives exactly one result item. An item is processed combinationally by
// the key scanner and screen control and lands in the output register, so one
// item is taken per clock as long as the output side keeps up; the result
// appears in the cycle after the item is taken. The output register is the only
// buffer: while it holds an untaken result, the input stalls. Configuration
// writes are always accepted (cfg_ready is tied high) and should be issued
// only while no tick is in flight.
module key_press_page_screen_controller import kpp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    // Tick input
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // [0] btn_pressed, [7:1] zero
    // Result output
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,    // [1:0] btn_event, [3:2] page_now,
                                         // [4] screen_on_now, [5] redraw_pulse,
                                         // [6] clear_pulse, [7] zero
    // Configuration writes
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic               advance;
    logic [CNT_W-1:0]   long_reg;
    logic [CLICK_W-1:0] click_reg;
    logic [CNT_W-1:0]   idle_tmo_reg;
    key_status_t        key_st;
    screen_status_t     scr_st;
    logic               out_valid_reg;
    logic [EV_W-1:0]    out_ev_reg;
    screen_status_t     out_scr_reg;

    // Handshakes
    assign s_tready  = !out_valid_reg || m_tready;
    assign advance   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_reg     <= LONG_PRESS_RST;
            click_reg    <= CLICK_MIN_RST;
            idle_tmo_reg <= IDLE_TMO_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LONG_PRESS: long_reg     <= cfg_data;
                REG_CLICK_MIN:  click_reg    <= cfg_data[CLICK_W-1:0];
                REG_IDLE_TMO:   idle_tmo_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    kpp_key_scan u_key_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .btn_pressed (s_tdata[0]),
        .long_ticks  (long_reg),
        .click_ticks (click_reg),
        .status      (key_st)
    );

    kpp_screen_ctrl u_screen_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .key        (key_st),
        .idle_ticks (idle_tmo_reg),
        .status     (scr_st)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_ev_reg  <= key_st.event_code;
            out_scr_reg <= scr_st;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_scr_reg.clear, out_scr_reg.redraw, out_scr_reg.lit,
                       out_scr_reg.page, out_ev_reg};

    // Checks
    a_draw_lit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_scr_reg.redraw |-> out_scr_reg.lit)
        else $error("redraw pulse on a dark screen");

    a_clear_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_scr_reg.clear |-> !out_scr_reg.lit && !out_scr_reg.redraw)
        else $error("clear pulse with screen lit or redraw");

    a_ev_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_ev_reg == EV_NONE || out_ev_reg == EV_CLICK ||
                      out_ev_reg == EV_LONG))
        else $error("bad key event code");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !s_tvalid |=> !m_tvalid)
        else $error("result repeated after being taken");

endmodule

// ===== bench/key_press_checker.sv =====
// ----------------------------------------------------------------------------
// key_press_checker
// Watches the tick, result and register channels of the key press / page /
// screen controller, predicts one result item per accepted tick item and
// compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module key_press_checker import kpp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,    // [0] btn_pressed, [7:1] zero
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [7:0]       m_tdata,    // [1:0] btn_event, [3:2] page_now,
                                         // [4] screen_on_now, [5] redraw_pulse,
                                         // [6] clear_pulse, [7] zero
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic [PAGE_W-1:0] page;
        logic              lit;
        logic              redraw;
        logic              clear;
    } tick_result_t;

    // Mirrored registers
    logic [CNT_W-1:0]   hold_limit;
    logic [CLICK_W-1:0] click_limit;
    logic [CNT_W-1:0]   dark_limit;

    // Mirrored controller state
    logic               held;
    logic [CNT_W-1:0]   held_for;
    logic               long_done;
    logic [CNT_W-1:0]   quiet_for;
    logic [PAGE_W-1:0]  page;
    logic               lit;
    logic               draw_due;

    tick_result_t       result_q[$];

    initial fail_count = 0;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // One tick of the controller: key scan, event, idle blanking, redraw
    function automatic tick_result_t advance_tick(input logic down);
        tick_result_t    r;
        logic [EV_W-1:0] ev;
        r = '0;
        ev = EV_NONE;
        quiet_for = bump(quiet_for);

        if (!held) begin
            if (down) begin
                held = 1'b1;
                held_for = '0;
                long_done = 1'b0;
            end
        end else begin
            held_for = bump(held_for);
            if (down) begin
                if (!long_done && held_for >= hold_limit) begin
                    long_done = 1'b1;
                    ev = EV_LONG;
                end
            end else begin
                held = 1'b0;
                if (!long_done && held_for >= CNT_W'(click_limit))
                    ev = EV_CLICK;
            end
        end

        // A key event on a dark screen only wakes it; a long press still goes home
        if (ev != EV_NONE) begin
            quiet_for = '0;
            if (!lit) begin
                lit = 1'b1;
                if (ev == EV_LONG)
                    page = PAGE_HOME;
            end else if (ev == EV_LONG) begin
                page = PAGE_HOME;
            end else begin
                case (page)
                    PAGE_HOME: page = PAGE_TEMP;
                    PAGE_TEMP: page = PAGE_LIGHT;
                    default:   page = PAGE_TEMP;
                endcase
            end
            draw_due = 1'b1;
        end

        // Blank on idle, never while the key reads down
        if (!down && lit && quiet_for >= dark_limit) begin
            r.clear = 1'b1;
            lit = 1'b0;
            draw_due = 1'b0;
        end

        if (lit && draw_due) begin
            draw_due = 1'b0;
            r.redraw = 1'b1;
        end

        r.ev = ev;
        r.page = page;
        r.lit = lit;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t checker: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Channel monitor
    always @(posedge aclk) begin
        tick_result_t got;
        tick_result_t want;
        if (!aresetn) begin
            hold_limit  <= LONG_PRESS_RST;
            click_limit <= CLICK_MIN_RST;
            dark_limit  <= IDLE_TMO_RST;
            held        = 1'b0;
            held_for    = '0;
            long_done   = 1'b0;
            quiet_for   = '0;
            page        = PAGE_HOME;
            lit         = 1'b1;
            draw_due    = 1'b1;
            result_q.delete();
            pending     <= 0;
        end else begin
            // Result side first: it can only match items taken earlier
            if (m_tvalid && m_tready) begin
                got.ev     = m_tdata[1:0];
                got.page   = m_tdata[3:2];
                got.lit    = m_tdata[4];
                got.redraw = m_tdata[5];
                got.clear  = m_tdata[6];
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result item, tdata", int'(m_tdata), 0);
                end else begin
                    want = result_q.pop_front();
                    if (got.ev !== want.ev)
                        report_mismatch("btn_event", int'(got.ev), int'(want.ev));
                    if (got.page !== want.page)
                        report_mismatch("page_now", int'(got.page), int'(want.page));
                    if (got.lit !== want.lit)
                        report_mismatch("screen_on_now", int'(got.lit), int'(want.lit));
                    if (got.redraw !== want.redraw)
                        report_mismatch("redraw_pulse", int'(got.redraw),
                                        int'(want.redraw));
                    if (got.clear !== want.clear)
                        report_mismatch("clear_pulse", int'(got.clear), int'(want.clear));
                end
            end

            if (s_tvalid && s_tready)
                result_q.push_back(advance_tick(s_tdata[0]));

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LONG_PRESS: hold_limit  <= cfg_data;
                    REG_CLICK_MIN:  click_limit <= cfg_data[CLICK_W-1:0];
                    REG_IDLE_TMO:   dark_limit  <= cfg_data;
                    default: ;
                endcase
            end

            pending <= result_q.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives tick items and register writes into the key press / page / screen
// controller: a directed pass over clicks, long presses, wake-up, idle
// blanking and register extremes, then random press sequences under random
// settings with three back-pressure profiles. The checker does the compare.
// ----------------------------------------------------------------------------
module testbench;
    import kpp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 2_000_000;
    localparam int BLOCKS_PER_PHASE = 3;
    localparam int ITEMS_PER_BLOCK  = 60;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    // Current settings, used only to shape press lengths and key-up gaps
    int cur_long  = int'(LONG_PRESS_RST);
    int cur_click = int'(CLICK_MIN_RST);
    int cur_idle  = int'(IDLE_TMO_RST);

    key_press_page_screen_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    key_press_checker watch (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side stalls
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // One tick item, with random gaps ahead of it; valid stays high afterwards
    task automatic send_tick(input logic down);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, down};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic key_up(input int n);
        repeat (n) send_tick(1'b0);
    endtask

    // Held for n ticks, then one release tick
    task automatic press(input int n);
        repeat (n) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    task automatic set_config(input int long_t, input int click_t, input int idle_t);
        settle();
        write_reg(REG_LONG_PRESS, long_t);
        write_reg(REG_CLICK_MIN, click_t);
        write_reg(REG_IDLE_TMO, idle_t);
        cfg_valid <= 1'b0;
        cur_long  = long_t;
        cur_click = click_t;
        cur_idle  = idle_t;
    endtask

    // Random settings biased toward the edges
    task automatic random_config();
        int long_t;
        int click_t;
        int idle_t;
        case ($urandom_range(9))
            0:       long_t = 0;
            1:       long_t = 1;
            default: long_t = $urandom_range(2, 40);
        endcase
        case ($urandom_range(9))
            0:       click_t = 0;
            1:       click_t = 1023;
            default: click_t = $urandom_range(0, 30);
        endcase
        case ($urandom_range(9))
            0:       idle_t = 0;
            1:       idle_t = 1;
            default: idle_t = $urandom_range(2, 90);
        endcase
        set_config(long_t, click_t, idle_t);
    endtask

    // Press sequences with lengths around the click and long press thresholds
    task automatic press_sequences(input int n);
        int sent;
        int gap;
        int hold;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(9) == 0) begin
                // noise: raw random levels
                repeat (8) send_tick(1'($urandom_range(1)));
                sent += 8;
            end else begin
                gap = $urandom_range(0, ((cur_idle < 60) ? cur_idle : 60) + 4);
                key_up(gap);
                case ($urandom_range(5))
                    0:       hold = cur_click - 1;
                    1:       hold = cur_click;
                    2:       hold = cur_long;
                    3:       hold = cur_long + 1;
                    4:       hold = $urandom_range(1, cur_long + 3);
                    default: hold = $urandom_range(1, 6);
                endcase
                if (hold < 1)
                    hold = 1;
                if (hold > 100)
                    hold = 100;
                press(hold);
                sent += gap + hold + 1;
            end
        end
    endtask

    task automatic random_phase();
        repeat (BLOCKS_PER_PHASE) begin
            random_config();
            press_sequences(ITEMS_PER_BLOCK);
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_LONG_PRESS;
        cfg_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender rarely idles, receiver stalls often
        send_idle_pct = 12;
        stall_pct     = 74;

        // Settings after reset: first draw, then a click
        key_up(2);
        press(21);

        // Page walk, short press, long press, timeout and wake-ups
        set_config(3, 2, 12);
        press(2);
        press(1);
        press(3);
        press(5);
        key_up(14);
        press(3);
        key_up(14);
        press(6);

        // Held key past the timeout, after idle blanking; the release click wakes the screen
        set_config(40, 0, 5);
        key_up(8);
        press(30);

        // Zero long press and zero idle timeout
        set_config(0, 0, 0);
        press(2);
        key_up(3);
        press(1);

        random_phase();

        // Sender idles often, receiver rarely stalls
        send_idle_pct = 74;
        stall_pct     = 12;
        random_phase();

        // Full rate
        send_idle_pct = 0;
        stall_pct     = 0;

        // Largest register values: click threshold above its usual range
        set_config(65535, 1023, 65535);
        key_up(3);
        press(1023);

        random_phase();

        settle();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
sv/kpp_pkg.sv
sv/kpp_key_scan.sv
sv/kpp_screen_ctrl.sv
sv/key_press_page_screen_controller.sv
bench/key_press_checker.sv
bench/testbench.sv
